// ===== rtl/epr_pkg.sv =====
// Shared types, sizes and constants for the eye pixel renderer.
// Used by every module under rtl; depends on nothing else.
package epr_pkg;

	// Geometry of the images and of the view window.
	localparam int unsigned SCLERA_SIZE = 200;
	localparam int unsigned VIEW_SIZE = 160;
	localparam int unsigned IRIS_SIZE = 128;
	localparam int unsigned TEX_WIDTH = 256;
	localparam int unsigned TEX_HEIGHT = 64;

	// Store depths and index widths.
	localparam int unsigned SCL_DEPTH = SCLERA_SIZE * SCLERA_SIZE;
	localparam int unsigned POL_DEPTH = IRIS_SIZE * IRIS_SIZE;
	localparam int unsigned TEX_DEPTH = TEX_WIDTH * TEX_HEIGHT;
	localparam int unsigned SCL_AW = $clog2(SCL_DEPTH);
	localparam int unsigned POL_AW = $clog2(POL_DEPTH);
	localparam int unsigned TEX_AW = $clog2(TEX_DEPTH);

	// Highest pan value that keeps the view on the sclera image.
	localparam int unsigned PAN_MAX = (SCLERA_SIZE > VIEW_SIZE) ? SCLERA_SIZE - VIEW_SIZE : 0;
	// Offset of the iris square inside the sclera image (truncates toward zero).
	localparam int IRIS_OFF = (int'(SCLERA_SIZE) - int'(IRIS_SIZE)) / 2;
	// Ellipse limit: 625 * s > 2601 * V^2 holds exactly when s exceeds this bound.
	localparam longint ELL_LIM = (64'd2601 * VIEW_SIZE * VIEW_SIZE) / 64'd625;

	// Width of the full sclera address before the range check.
	localparam int unsigned SCL_ADDR_W = 18;

	// Item kinds carried in tuser.
	typedef enum logic [1:0] {
		FN_WR_SCLERA = 2'd0,
		FN_WR_POLAR  = 2'd1,
		FN_WR_IRIS   = 2'd2,
		FN_RENDER    = 2'd3
	} func_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_IRIS_SCALE = 2'd0,
		CFG_PAN_X      = 2'd1,
		CFG_PAN_Y      = 2'd2,
		CFG_BLINK      = 2'd3
	} cfg_idx_t;

	// Per-item control that travels down the pipeline.
	typedef struct packed {
		logic              v;
		func_t             func;
		logic [15:0]       waddr;
		logic [15:0]       wdata;
		logic              black;
		logic              in_iris;
		logic              scl_ok;
		logic [SCL_AW-1:0] scl_idx;
	} item_t;

	// Texture lookup decision made after the polar read.
	typedef struct packed {
		logic use_iris;
		logic tex_ok;
	} tex_sel_t;

endpackage

// ===== rtl/eye_pixel_renderer.sv =====
// Eye pixel renderer: input and output stream ports, configuration registers, output register.
// Instantiates epr_geom, epr_polar and epr_texel; depends on epr_pkg.
//
// Usage:
//   The slave stream carries one word per item. tuser selects the kind: write sclera image,
//   write polar map, write iris texture, or render one pixel. Write words store table_data at
//   table_addr and give no output; render words give exactly one pixel word on the master
//   stream, in input order. Writes and renders may be freely interleaved: a render sees every
//   write accepted before it.
//   Configuration (iris scale, pan x/y, blink height) is written through cfg_we/cfg_addr/
//   cfg_data while the stream is idle.
// Timing:
//   Six pipeline stages plus the output register, through which each render word passes to m_tdata.
//   One word is accepted every cycle while the output does not stall; throughput is set by the
//   image stores, each read once and written at most once per cycle.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults; image store contents are
//   undefined until written. When m_tready is low with a pixel waiting, the whole pipeline
//   holds and s_tready drops in the same cycle; nothing is lost or repeated.
module eye_pixel_renderer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // table_addr[15:0], table_data[31:16], screen_x[39:32], screen_y[47:40]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // pixel[15:0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [9:0]  cfg_data
);

	logic                       adv;
	logic [9:0]                 iris_scale_q;
	logic [7:0]                 pan_x_q, pan_y_q, blink_q;
	logic                       m_tvalid_q;
	logic [15:0]                m_tdata_q;

	epr_pkg::item_t             item_s2, item_s5, item_s6;
	logic [epr_pkg::POL_AW-1:0] pol_idx_s2;
	epr_pkg::tex_sel_t          sel_s5;
	logic [epr_pkg::TEX_AW-1:0] tex_idx_s5;
	logic [15:0]                pixel;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iris_scale_q <= 10'd512;
			pan_x_q      <= 8'd20;
			pan_y_q      <= 8'd20;
			blink_q      <= 8'd0;
		end else if (cfg_we) begin
			case (epr_pkg::cfg_idx_t'(cfg_addr))
				epr_pkg::CFG_IRIS_SCALE: iris_scale_q <= cfg_data;
				epr_pkg::CFG_PAN_X:      pan_x_q <= cfg_data[7:0];
				epr_pkg::CFG_PAN_Y:      pan_y_q <= cfg_data[7:0];
				epr_pkg::CFG_BLINK:      blink_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	epr_geom u_geom (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_v         (s_tvalid),
		.func         (epr_pkg::func_t'(s_tuser)),
		.table_addr   (s_tdata[15:0]),
		.table_data   (s_tdata[31:16]),
		.screen_x     (s_tdata[39:32]),
		.screen_y     (s_tdata[47:40]),
		.pan_x        (pan_x_q),
		.pan_y        (pan_y_q),
		.blink_height (blink_q),
		.item_s2      (item_s2),
		.pol_idx_s2   (pol_idx_s2)
	);

	epr_polar u_polar (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.iris_scale (iris_scale_q),
		.item_s2    (item_s2),
		.pol_idx_s2 (pol_idx_s2),
		.item_s5    (item_s5),
		.sel_s5     (sel_s5),
		.tex_idx_s5 (tex_idx_s5)
	);

	epr_texel u_texel (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_s5    (item_s5),
		.sel_s5     (sel_s5),
		.tex_idx_s5 (tex_idx_s5),
		.item_s6    (item_s6),
		.pixel      (pixel)
	);

	// Output register: only render words produce a pixel word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= item_s6.v && (item_s6.func == epr_pkg::FN_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= pixel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// A store write leaving the pipeline never shows up as a pixel word.
	a_write_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s6.v && (item_s6.func != epr_pkg::FN_RENDER) |=> !m_tvalid)
		else $error("write word produced an output pixel");

	// A render word marked black leaves as a zero pixel.
	a_black_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s6.v && (item_s6.func == epr_pkg::FN_RENDER) && item_s6.black
		|=> m_tvalid && (m_tdata == 16'h0000))
		else $error("black pixel not zero");

	// While the output stalls, the last pipeline stage holds its word.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(item_s6) && $stable(pixel))
		else $error("pipeline moved during stall");

	// A render word in stage 6 reaches the output register at the next movement.
	a_render_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s6.v && (item_s6.func == epr_pkg::FN_RENDER) |=> m_tvalid)
		else $error("render word lost before output");

endmodule

// ===== rtl/epr_geom.sv =====
// Stages 1 and 2: view coordinates, pan clamp, blink and ellipse tests, store addresses.
// Depends on epr_pkg.
module epr_geom (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_v,
	input  epr_pkg::func_t             func,
	input  logic [15:0]                table_addr,
	input  logic [15:0]                table_data,
	input  logic [7:0]                 screen_x,
	input  logic [7:0]                 screen_y,
	input  logic [7:0]                 pan_x,
	input  logic [7:0]                 pan_y,
	input  logic [7:0]                 blink_height,
	output epr_pkg::item_t             item_s2,
	output logic [epr_pkg::POL_AW-1:0] pol_idx_s2
);

	localparam int unsigned SCL_ADDR_W_L = epr_pkg::SCL_ADDR_W;

	logic [7:0]         pan_xc, pan_yc;
	logic               black_in;
	logic signed [10:0] dx, dy;
	logic signed [21:0] dx2_full, dy2_full;

	epr_pkg::item_t     item_s1;
	logic [8:0]         cx_s1, cy_s1;
	logic [17:0]        dx2_s1, dy2_s1;

	logic [21:0]        ell_sum;
	logic signed [10:0] ix, iy;
	logic               in_iris;
	logic [16:0]        pol_addr;
	logic [SCL_ADDR_W_L-1:0] scl_addr;

	// Pan clamp: a pan that runs the view off the image falls back to the maximum.
	always_comb begin
		pan_xc = pan_x;
		pan_yc = pan_y;
		if (({2'b0, pan_x} + 10'(epr_pkg::VIEW_SIZE)) > 10'(epr_pkg::SCLERA_SIZE)) begin
			pan_xc = 8'(epr_pkg::PAN_MAX);
		end
		if (({2'b0, pan_y} + 10'(epr_pkg::VIEW_SIZE)) > 10'(epr_pkg::SCLERA_SIZE)) begin
			pan_yc = 8'(epr_pkg::PAN_MAX);
		end
	end

	// Out-of-view coordinates and blink bands both give black.
	always_comb begin
		black_in = ({1'b0, screen_x} >= 9'(epr_pkg::VIEW_SIZE)) ||
			({1'b0, screen_y} >= 9'(epr_pkg::VIEW_SIZE)) ||
			(screen_y < blink_height) ||
			(({1'b0, screen_y} + {1'b0, blink_height}) >= 9'(epr_pkg::VIEW_SIZE));
	end

	// Ellipse distances from the view center, doubled to stay integer.
	assign dx = $signed({2'b0, screen_x, 1'b0}) - 11'sd0 - $signed(11'(epr_pkg::VIEW_SIZE));
	assign dy = $signed({2'b0, screen_y, 1'b0}) - 11'sd0 - $signed(11'(epr_pkg::VIEW_SIZE));
	assign dx2_full = dx * dx;
	assign dy2_full = dy * dy;

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1.v       <= in_v;
			item_s1.func    <= func;
			item_s1.waddr   <= table_addr;
			item_s1.wdata   <= table_data;
			item_s1.black   <= black_in;
			item_s1.in_iris <= 1'b0;
			item_s1.scl_ok  <= 1'b0;
			item_s1.scl_idx <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1  <= {1'b0, pan_xc} + {1'b0, screen_x};
			cy_s1  <= {1'b0, pan_yc} + {1'b0, screen_y};
			dx2_s1 <= dx2_full[17:0];
			dy2_s1 <= dy2_full[17:0];
		end
	end

	// Ellipse test against the exact rational bound.
	assign ell_sum = {dx2_s1, 2'b0} + 22'(dy2_s1) * 22'd9;

	// Iris square membership and store addresses.
	assign ix = $signed({2'b0, cx_s1}) - 11'(epr_pkg::IRIS_OFF);
	assign iy = $signed({2'b0, cy_s1}) - 11'(epr_pkg::IRIS_OFF);
	assign in_iris = (ix >= 11'sd0) && (ix < $signed(11'(epr_pkg::IRIS_SIZE))) &&
		(iy >= 11'sd0) && (iy < $signed(11'(epr_pkg::IRIS_SIZE)));
	assign pol_addr = 17'(iy[8:0]) * 17'(epr_pkg::IRIS_SIZE) + 17'(ix[8:0]);
	assign scl_addr = SCL_ADDR_W_L'(cy_s1) * SCL_ADDR_W_L'(epr_pkg::SCLERA_SIZE) +
		SCL_ADDR_W_L'(cx_s1);

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else if (adv) begin
			item_s2.v       <= item_s1.v;
			item_s2.func    <= item_s1.func;
			item_s2.waddr   <= item_s1.waddr;
			item_s2.wdata   <= item_s1.wdata;
			item_s2.black   <= item_s1.black || (ell_sum > 22'(epr_pkg::ELL_LIM));
			item_s2.in_iris <= in_iris;
			item_s2.scl_ok  <= scl_addr < SCL_ADDR_W_L'(epr_pkg::SCL_DEPTH);
			item_s2.scl_idx <= scl_addr[epr_pkg::SCL_AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pol_idx_s2 <= pol_addr[epr_pkg::POL_AW-1:0];
		end
	end

endmodule

// ===== rtl/epr_polar.sv =====
// Stages 3 to 5: polar map store, distance and angle scaling, texture address.
// Depends on epr_pkg.
module epr_polar (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [9:0]                 iris_scale,
	input  epr_pkg::item_t             item_s2,
	input  logic [epr_pkg::POL_AW-1:0] pol_idx_s2,
	output epr_pkg::item_t             item_s5,
	output epr_pkg::tex_sel_t          sel_s5,
	output logic [epr_pkg::TEX_AW-1:0] tex_idx_s5
);

	logic [15:0]    pol_mem [epr_pkg::POL_DEPTH];
	logic [16:0]    waddr_ext;
	logic           pol_we;

	epr_pkg::item_t item_s3, item_s4;
	logic [15:0]    p_s3;
	logic [16:0]    dist_prod;
	logic [19:0]    ang_prod;
	logic [9:0]     d_s4;
	logic [10:0]    a_s4;
	logic [20:0]    tex_addr;

	// Polar writes land in the same stage as polar reads, keeping item order.
	assign waddr_ext = {1'b0, item_s2.waddr};
	assign pol_we = adv && item_s2.v && (item_s2.func == epr_pkg::FN_WR_POLAR) &&
		(waddr_ext < 17'(epr_pkg::POL_DEPTH));

	always_ff @(posedge clk) begin
		if (pol_we) begin
			pol_mem[waddr_ext[epr_pkg::POL_AW-1:0]] <= item_s2.wdata;
		end
		if (adv) begin
			p_s3 <= pol_mem[pol_idx_s2];
		end
	end

	// Scale polar distance by iris_scale and angle to the texture width.
	assign dist_prod = 17'(iris_scale) * 17'(p_s3[6:0]);
	assign ang_prod = 20'(p_s3[15:7]) * 20'(epr_pkg::TEX_WIDTH);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s4 <= dist_prod[16:7];
			a_s4 <= ang_prod[19:9];
		end
	end

	// Texel address; distances past the texture fall back to the sclera.
	assign tex_addr = 21'(d_s4) * 21'(epr_pkg::TEX_WIDTH) + 21'(a_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			tex_idx_s5 <= tex_addr[epr_pkg::TEX_AW-1:0];
		end
	end

	// Control registers for stages 3 to 5.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s3 <= '0;
			item_s4 <= '0;
			item_s5 <= '0;
			sel_s5  <= '0;
		end else if (adv) begin
			item_s3         <= item_s2;
			item_s4         <= item_s3;
			item_s5         <= item_s4;
			sel_s5.use_iris <= item_s4.in_iris && (d_s4 < 10'(epr_pkg::TEX_HEIGHT));
			sel_s5.tex_ok   <= tex_addr < 21'(epr_pkg::TEX_DEPTH);
		end
	end

endmodule

// ===== rtl/epr_texel.sv =====
// Stage 6: sclera and iris texture stores, final color selection and byte swap.
// Depends on epr_pkg.
module epr_texel (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  epr_pkg::item_t             item_s5,
	input  epr_pkg::tex_sel_t          sel_s5,
	input  logic [epr_pkg::TEX_AW-1:0] tex_idx_s5,
	output epr_pkg::item_t             item_s6,
	output logic [15:0]                pixel
);

	logic [15:0]       scl_mem [epr_pkg::SCL_DEPTH];
	logic [15:0]       tex_mem [epr_pkg::TEX_DEPTH];
	logic [17:0]       waddr_ext;
	logic              scl_we, tex_we;

	epr_pkg::tex_sel_t sel_s6;
	logic [15:0]       scl_s6, tex_s6;
	logic [15:0]       color;

	// Writes to both stores happen in the stage that reads them.
	assign waddr_ext = {2'b0, item_s5.waddr};
	assign scl_we = adv && item_s5.v && (item_s5.func == epr_pkg::FN_WR_SCLERA) &&
		(waddr_ext < 18'(epr_pkg::SCL_DEPTH));
	assign tex_we = adv && item_s5.v && (item_s5.func == epr_pkg::FN_WR_IRIS) &&
		(waddr_ext < 18'(epr_pkg::TEX_DEPTH));

	always_ff @(posedge clk) begin
		if (scl_we) begin
			scl_mem[waddr_ext[epr_pkg::SCL_AW-1:0]] <= item_s5.wdata;
		end
		if (adv) begin
			scl_s6 <= scl_mem[item_s5.scl_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (tex_we) begin
			tex_mem[waddr_ext[epr_pkg::TEX_AW-1:0]] <= item_s5.wdata;
		end
		if (adv) begin
			tex_s6 <= tex_mem[tex_idx_s5];
		end
	end

	// Stage 6 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s6 <= '0;
			sel_s6  <= '0;
		end else if (adv) begin
			item_s6 <= item_s5;
			sel_s6  <= sel_s5;
		end
	end

	// Pick black, iris texel or sclera pixel; addresses off a store read as zero.
	always_comb begin
		if (item_s6.black) begin
			color = 16'h0000;
		end else if (sel_s6.use_iris) begin
			color = sel_s6.tex_ok ? tex_s6 : 16'h0000;
		end else begin
			color = item_s6.scl_ok ? scl_s6 : 16'h0000;
		end
	end

	assign pixel = {color[7:0], color[15:8]};

endmodule
